>>> hdl/ibc_pkg.sv
// ----------------------------------------------------------------------------
// ibc_pkg
// Shared types, register indexes and modulo-65537 helpers for the cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package ibc_pkg;

	localparam int WordW = 16;
	localparam int RowW  = 6 * WordW;

	// configuration register indexes
	localparam logic [1:0] REG_KEY_HIGH    = 2'd0;
	localparam logic [1:0] REG_KEY_LOW     = 2'd1;
	localparam logic [1:0] REG_KEY_LENGTH  = 2'd2;
	localparam logic [1:0] REG_ROUND_COUNT = 2'd3;

	typedef logic [WordW-1:0] word_t;

	// key ring control
	typedef struct packed {
		logic load;
		logic shift;
		logic jump;
	} ring_ctrl_t;

	// reduce a registered 16x16 product modulo 65537; a word of 0 stands for 65536
	function automatic word_t mm_reduce(input logic [31:0] p, input word_t a, input word_t b);
		logic [31:0] q;
		begin
			q = {16'd0, p[15:0]} - {16'd0, p[31:16]};
			if (p != 32'd0) begin
				mm_reduce = q[15:0] - q[31:16];
			end else begin
				mm_reduce = 16'd1 - a - b;
			end
		end
	endfunction

	function automatic word_t neg16(input word_t x);
		begin
			neg16 = (~x) + 16'd1;
		end
	endfunction

endpackage

`default_nettype wire

>>> hdl/ibc_key_cell.sv
// ----------------------------------------------------------------------------
// ibc_key_cell
// One 16-bit word of the key ring: load, pass to the left, or jump by 25 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ibc_key_cell (
	input  wire logic               clk,
	input  wire ibc_pkg::ring_ctrl_t ctrl,
	input  wire ibc_pkg::word_t     load_word,
	input  wire ibc_pkg::word_t     nb1,
	input  wire ibc_pkg::word_t     nb2,
	input  wire ibc_pkg::word_t     nb3,
	output ibc_pkg::word_t          word
);

	ibc_pkg::word_t word_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			word_q <= load_word;
		end else if (ctrl.jump) begin
			// finish the word rotation and rotate the block left by 25 bits
			word_q <= {nb2[6:0], nb3[15:7]};
		end else if (ctrl.shift) begin
			word_q <= nb1;
		end
	end

	assign word = word_q;

endmodule

`default_nettype wire

>>> hdl/ibc_key_ring.sv
// ----------------------------------------------------------------------------
// ibc_key_ring
// Ring of eight key cells; cell 0 presents one encryption subkey per cycle while the ring shifts or jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module ibc_key_ring (
	input  wire logic                clk,
	input  wire ibc_pkg::ring_ctrl_t ctrl,
	input  wire logic [127:0]        key,
	output ibc_pkg::word_t           word0
);

	ibc_pkg::word_t cw [8];

	for (genvar k = 0; k < 8; k++) begin : g_cell
		ibc_key_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.load_word (key[127-16*k -: 16]),
			.nb1       (cw[(k+1)%8]),
			.nb2       (cw[(k+2)%8]),
			.nb3       (cw[(k+3)%8]),
			.word      (cw[k])
		);
	end

	assign word0 = cw[0];

endmodule

`default_nettype wire

>>> hdl/ibc_mulinv.sv
// ----------------------------------------------------------------------------
// ibc_mulinv
// Multiplicative inverse modulo 65537 as x^65535 by square and multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module ibc_mulinv (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire ibc_pkg::word_t x,
	output logic                done,
	output ibc_pkg::word_t      y
);

	ibc_pkg::word_t y_q, x_q, a_q, b_q, op_b, red;
	logic [31:0]    p_q;
	logic [3:0]     cnt_q;
	logic           mul_q, red_q, busy_q;

	assign op_b = mul_q ? x_q : y_q;
	assign red  = ibc_pkg::mm_reduce(p_q, a_q, b_q);
	assign done = busy_q && red_q && mul_q && (cnt_q == 4'd14);
	assign y    = red;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			red_q  <= 1'b0;
			mul_q  <= 1'b0;
			cnt_q  <= 4'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			red_q  <= 1'b0;
			mul_q  <= 1'b0;
			cnt_q  <= 4'd0;
		end else if (busy_q) begin
			red_q <= !red_q;
			if (red_q) begin
				mul_q <= !mul_q;
				if (mul_q) begin
					cnt_q <= cnt_q + 4'd1;
				end
				if (done) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			y_q <= x;
			x_q <= x;
		end else if (busy_q) begin
			if (!red_q) begin
				p_q <= 32'(y_q) * 32'(op_b);
				a_q <= y_q;
				b_q <= op_b;
			end else begin
				y_q <= red;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/idea_block_cipher.sv
// ----------------------------------------------------------------------------
// idea_block_cipher
// IDEA cipher, 64-bit block, 128-bit key, configurable round count.
// ----------------------------------------------------------------------------
// Usage: write key_high, key_low, key_length and round_count through the
// cfg_we / cfg_index / cfg_data port while the block is idle. Each input
// transaction (in_valid, in_stall) carries action (0 encrypt, 1 decrypt) and
// block_in; each output transaction (out_valid, out_stall) carries block_out.
// Subkeys live in a table of 96-bit rows, one per round and one for the
// output transform, per direction. After reset or any configuration write
// the table is stale: the next transaction first regenerates it, the
// encryption subkeys from the eight-cell key ring, then the r+1 decryption
// rows through the single inversion unit, two inversions per row.
// With the table fresh a transaction goes from acceptance to the result
// register through one table read, then the round states R1 to R4 for each
// round in the shared round unit (three dependent modular multiplies, each
// with a product register), and the states F1 and F2 for the output transform.
// One transaction is in work at a time; in_stall is high while it is.
// A result held by out_stall stays in the output register; a finished
// transaction waits for that register before the next one is taken.
// Reset clears the handshake state, restores the register defaults and marks
// the subkey table stale.
// ----------------------------------------------------------------------------
`default_nettype none

module idea_block_cipher #(
	parameter int MAX_ROUNDS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [63:0] block_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      block_out
);

	localparam int RW = $clog2(MAX_ROUNDS + 1);
	localparam int AW = RW + 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_KGEN = 4'd1;
	localparam logic [3:0] S_DA   = 4'd2;
	localparam logic [3:0] S_DB   = 4'd3;
	localparam logic [3:0] S_DC   = 4'd4;
	localparam logic [3:0] S_DD   = 4'd5;
	localparam logic [3:0] S_DE   = 4'd6;
	localparam logic [3:0] S_C0   = 4'd7;
	localparam logic [3:0] S_R1   = 4'd8;
	localparam logic [3:0] S_R2   = 4'd9;
	localparam logic [3:0] S_R3   = 4'd10;
	localparam logic [3:0] S_R4   = 4'd11;
	localparam logic [3:0] S_F1   = 4'd12;
	localparam logic [3:0] S_F2   = 4'd13;
	localparam logic [3:0] S_OUT  = 4'd14;

	// configuration
	logic [63:0] key_high_q, key_low_q;
	logic [4:0]  key_length_q, round_count_q;
	logic        keys_ok_q;

	// control
	logic [3:0]    st_q;
	logic          act_q;
	logic [RW-1:0] row_q, di_q, rr, row_nx;
	logic [2:0]    slot_q, blk_q;
	logic          ov_q;

	// datapath
	ibc_pkg::word_t w0_q, w1_q, w2_q, w3_q, u_q, a0_q, b0_q, a3_q, b3_q;
	ibc_pkg::word_t dk0_q, dk3_q, m0, m3, tu, tv, u2;
	logic [31:0]    p0_q, p3_q;
	logic [95:0]    acc_q, acc_n, rd_q, key_q, wr_data;
	logic [63:0]    src_q, res_q;
	logic [127:0]   key_raw, key_m;
	logic [4:0]     len_c;
	logic [6:0]     req_r;

	// subkey table: rows 0..r encryption, rows with the top address bit decryption
	logic [95:0]   ks_mem [2**AW];
	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;

	ibc_pkg::ring_ctrl_t ring_ctrl;
	ibc_pkg::word_t      ring_word;

	logic           inv_start, inv_done, kgen_last, sw;
	ibc_pkg::word_t inv_x, inv_y;

	// effective round count and key
	always_comb begin
		req_r   = (round_count_q == 5'd0) ? 7'd8 : {2'b0, round_count_q};
		rr      = (req_r > 7'(MAX_ROUNDS)) ? RW'(MAX_ROUNDS) : RW'(req_r);
		len_c   = (key_length_q > 5'd16) ? 5'd16 : key_length_q;
		key_raw = {key_high_q, key_low_q};
		for (int b = 0; b < 16; b++) begin
			key_m[127-8*b -: 8] = (5'(b) < len_c) ? key_raw[127-8*b -: 8] : 8'd0;
		end
	end

	assign in_stall  = (st_q != S_IDLE);
	assign out_valid = ov_q;

	// key ring feeds one encryption subkey per cycle while the encryption rows are built
	always_comb begin
		ring_ctrl.load  = (st_q == S_IDLE) && in_valid;
		ring_ctrl.shift = (st_q == S_KGEN) && (blk_q != 3'd7);
		ring_ctrl.jump  = (st_q == S_KGEN) && (blk_q == 3'd7);
	end

	ibc_key_ring u_ring (
		.clk   (clk),
		.ctrl  (ring_ctrl),
		.key   (key_m),
		.word0 (ring_word)
	);

	always_comb begin
		acc_n = acc_q;
		acc_n[95-16*slot_q -: 16] = ring_word;
	end

	assign kgen_last = (row_q == rr) && (slot_q == 3'd3);

	// inversion unit
	assign inv_start = (st_q == S_DB) || ((st_q == S_DC) && inv_done);
	assign inv_x     = (st_q == S_DB) ? rd_q[95:80] : src_q[15:0];

	ibc_mulinv u_inv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (inv_start),
		.x      (inv_x),
		.done   (inv_done),
		.y      (inv_y)
	);

	// decryption row: middle rows swap the two additive subkeys
	assign sw = (di_q != '0) && (di_q != rr);

	// table ports
	assign row_nx = row_q + RW'(1);
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = {1'b0, row_q};
		wr_data = acc_n;
		case (st_q)
			S_KGEN: begin
				wr_en = (slot_q == 3'd5) || kgen_last;
			end
			S_DE: begin
				wr_en   = 1'b1;
				wr_addr = {1'b1, di_q};
				wr_data = {dk0_q,
					ibc_pkg::neg16(sw ? src_q[31:16] : src_q[47:32]),
					ibc_pkg::neg16(sw ? src_q[47:32] : src_q[31:16]),
					dk3_q,
					(di_q != rr) ? rd_q[31:0] : 32'd0};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (st_q)
			S_DA:    rd_addr = {1'b0, rr - di_q};
			S_DD:    rd_addr = {1'b0, rr - di_q - RW'(1)};
			S_C0:    rd_addr = {act_q, {RW{1'b0}}};
			S_R4:    rd_addr = {act_q, row_nx};
			default: rd_addr = {act_q, row_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ks_mem[wr_addr] <= wr_data;
		end
		rd_q <= ks_mem[rd_addr];
	end

	// round unit
	assign m0 = ibc_pkg::mm_reduce(p0_q, a0_q, b0_q);
	assign m3 = ibc_pkg::mm_reduce(p3_q, a3_q, b3_q);
	assign tu = m0 ^ w2_q;
	assign tv = m0 + (w1_q ^ w3_q);
	assign u2 = u_q + m0;

	// sequencer and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= S_IDLE;
			ov_q          <= 1'b0;
			keys_ok_q     <= 1'b0;
			key_high_q    <= 64'd0;
			key_low_q     <= 64'd0;
			key_length_q  <= 5'd16;
			round_count_q <= 5'd8;
			row_q         <= '0;
			di_q          <= '0;
			slot_q        <= 3'd0;
			blk_q         <= 3'd0;
		end else begin
			if (cfg_we) begin
				keys_ok_q <= 1'b0;
				case (cfg_index)
					ibc_pkg::REG_KEY_HIGH:    key_high_q    <= cfg_data;
					ibc_pkg::REG_KEY_LOW:     key_low_q     <= cfg_data;
					ibc_pkg::REG_KEY_LENGTH:  key_length_q  <= cfg_data[4:0];
					ibc_pkg::REG_ROUND_COUNT: round_count_q <= cfg_data[4:0];
					default:                  key_high_q    <= key_high_q;
				endcase
			end
			// drop the presented result once taken, unless a new one replaces it
			if (ov_q && !out_stall && (st_q != S_OUT)) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						row_q  <= '0;
						slot_q <= 3'd0;
						blk_q  <= 3'd0;
						st_q   <= keys_ok_q ? S_C0 : S_KGEN;
					end
				end
				S_KGEN: begin
					blk_q <= blk_q + 3'd1;
					if (kgen_last) begin
						di_q <= '0;
						st_q <= S_DA;
					end else if (slot_q == 3'd5) begin
						slot_q <= 3'd0;
						row_q  <= row_nx;
					end else begin
						slot_q <= slot_q + 3'd1;
					end
				end
				S_DA: st_q <= S_DB;
				S_DB: st_q <= S_DC;
				S_DC: begin
					if (inv_done) begin
						st_q <= S_DD;
					end
				end
				S_DD: begin
					if (inv_done) begin
						st_q <= S_DE;
					end
				end
				S_DE: begin
					if (di_q == rr) begin
						keys_ok_q <= 1'b1;
						st_q      <= S_C0;
					end else begin
						di_q <= di_q + RW'(1);
						st_q <= S_DA;
					end
				end
				S_C0: begin
					row_q <= '0;
					st_q  <= S_R1;
				end
				S_R1: st_q <= S_R2;
				S_R2: st_q <= S_R3;
				S_R3: st_q <= S_R4;
				S_R4: begin
					row_q <= row_nx;
					st_q  <= (row_nx == rr) ? S_F1 : S_R1;
				end
				S_F1: st_q <= S_F2;
				S_F2: st_q <= S_OUT;
				S_OUT: begin
					if (!ov_q || !out_stall) begin
						ov_q <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				act_q <= action;
				w0_q  <= block_in[63:48];
				w1_q  <= block_in[47:32];
				w2_q  <= block_in[31:16];
				w3_q  <= block_in[15:0];
			end
			S_KGEN: acc_q <= acc_n;
			S_DB:   src_q <= rd_q[95:32];
			S_DC: begin
				if (inv_done) begin
					dk0_q <= inv_y;
				end
			end
			S_DD: begin
				if (inv_done) begin
					dk3_q <= inv_y;
				end
			end
			S_R1, S_F1: begin
				key_q <= rd_q;
				p0_q  <= 32'(w0_q) * 32'(rd_q[95:80]);
				a0_q  <= w0_q;
				b0_q  <= rd_q[95:80];
				p3_q  <= 32'(w3_q) * 32'(rd_q[47:32]);
				a3_q  <= w3_q;
				b3_q  <= rd_q[47:32];
				// the output transform adds the two middle subkeys crosswise
				if (st_q == S_R1) begin
					w1_q <= w1_q + rd_q[79:64];
					w2_q <= w2_q + rd_q[63:48];
				end else begin
					w2_q <= w2_q + rd_q[79:64];
					w1_q <= w1_q + rd_q[63:48];
				end
			end
			S_R2: begin
				w0_q <= m0;
				w3_q <= m3;
				p0_q <= 32'(tu) * 32'(key_q[31:16]);
				a0_q <= tu;
				b0_q <= key_q[31:16];
			end
			S_R3: begin
				u_q  <= m0;
				p0_q <= 32'(tv) * 32'(key_q[15:0]);
				a0_q <= tv;
				b0_q <= key_q[15:0];
			end
			S_R4: begin
				w0_q <= w0_q ^ m0;
				w3_q <= w3_q ^ u2;
				w1_q <= w2_q ^ m0;
				w2_q <= u2 ^ w1_q;
			end
			S_F2: res_q <= {m0, w2_q, w1_q, m3};
			S_OUT: begin
				if (!ov_q || !out_stall) begin
					block_out <= res_q;
				end
			end
			default: act_q <= act_q;
		endcase
	end

	ap_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (st_q != S_IDLE))
		else $error("accepted transaction left the sequencer idle");

	ap_inv_done: assert property (@(posedge clk) disable iff (!arst_n)
		inv_done |-> ((st_q == S_DC) || (st_q == S_DD)))
		else $error("inversion finished outside the decryption key build");

	ap_table_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((st_q == S_KGEN) || (st_q == S_DE)))
		else $error("subkey table written outside the key build");

	ap_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == S_OUT) && !out_stall) |=> out_valid)
		else $error("finished result not presented");

endmodule

`default_nettype wire

>>> test/ibc_checker.sv
// ----------------------------------------------------------------------------
// ibc_checker
// Watches the configuration port and both transaction channels of the cipher,
// predicts each result from its own model and compares it with the output.
// ----------------------------------------------------------------------------
`default_nettype none

module ibc_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        action,
	input  wire logic [63:0] block_in,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [63:0] block_out,
	output int               fail_count,
	output int               pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MaxRounds = 16;
	localparam int Depth = 6 * MaxRounds + 4;

	logic [63:0] key_hi_q, key_lo_q;
	logic [4:0]  key_len_q, rounds_q;
	logic [63:0] block_queue[$];

	function automatic logic [15:0] mul_65537(logic [15:0] a, logic [15:0] b);
		logic [31:0] p, q;
		logic [15:0] r;
		p = a * b;
		if (p != 0) begin
			q = {16'd0, p[15:0]} - {16'd0, p[31:16]};
			r = q[15:0] - q[31:16];
		end else begin
			r = 16'd1 - a - b;
		end
		return r;
	endfunction

	function automatic logic [15:0] inv_65537(logic [15:0] x);
		logic [15:0] y;
		y = x;
		for (int n = 0; n < 15; n++) begin
			y = mul_65537(y, y);
			y = mul_65537(y, x);
		end
		return y;
	endfunction

	function automatic logic [63:0] cipher_block(logic dec, logic [63:0] blk);
		logic [15:0] ek[Depth], dk[Depth], k[Depth];
		logic [15:0] w0, w1, w2, w3, u, v;
		int r, len, base, s, t, m, n;
		r = (rounds_q == 0) ? 8 : rounds_q;
		if (r > MaxRounds) r = MaxRounds;
		len = (key_len_q > 16) ? 16 : key_len_q;
		for (int i = 0; i < Depth; i++) begin
			ek[i] = '0;
			dk[i] = '0;
		end
		for (int b = 0; b < len; b++) begin
			logic [7:0] by;
			by = (b < 8) ? key_hi_q[63 - 8*b -: 8] : key_lo_q[63 - 8*(b-8) -: 8];
			if (b % 2 == 0) ek[b/2][15:8] = by;
			else ek[b/2][7:0] = by;
		end
		for (int i = 8; i < 6*r + 4; i++) begin
			base = (i & ~7) - 8;
			ek[i] = {ek[base + ((i+1) & 7)][6:0], ek[base + ((i+2) & 7)][15:7]};
		end
		for (int i = 0; i < r; i++) begin
			s = (r - i) * 6;
			m = (i > 0) ? 1 : 0;
			t = (r - 1 - i) * 6;
			dk[i*6]   = inv_65537(ek[s]);
			dk[i*6+1] = -ek[s+1+m];
			dk[i*6+2] = -ek[s+2-m];
			dk[i*6+3] = inv_65537(ek[s+3]);
			dk[i*6+4] = ek[t+4];
			dk[i*6+5] = ek[t+5];
		end
		dk[r*6]   = inv_65537(ek[0]);
		dk[r*6+1] = -ek[1];
		dk[r*6+2] = -ek[2];
		dk[r*6+3] = inv_65537(ek[3]);
		if (dec) k = dk;
		else k = ek;
		{w0, w1, w2, w3} = blk;
		n = 0;
		for (int rd = 0; rd < r; rd++) begin
			w0 = mul_65537(w0, k[n]);
			w1 = w1 + k[n+1];
			w2 = w2 + k[n+2];
			w3 = mul_65537(w3, k[n+3]);
			u = mul_65537(w0 ^ w2, k[n+4]);
			v = mul_65537(u + (w1 ^ w3), k[n+5]);
			u = u + v;
			w0 = w0 ^ v;
			w3 = w3 ^ u;
			u = u ^ w1;
			w1 = w2 ^ v;
			w2 = u;
			n += 6;
		end
		w0 = mul_65537(w0, k[n]);
		w2 = w2 + k[n+1];
		w1 = w1 + k[n+2];
		w3 = mul_65537(w3, k[n+3]);
		return {w0, w2, w1, w3};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
			key_len_q <= 5'd16;
			rounds_q <= 5'd8;
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ibc_pkg::REG_KEY_HIGH: key_hi_q <= cfg_data;
					ibc_pkg::REG_KEY_LOW: key_lo_q <= cfg_data;
					ibc_pkg::REG_KEY_LENGTH: key_len_q <= cfg_data[4:0];
					ibc_pkg::REG_ROUND_COUNT: rounds_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				block_queue.push_back(cipher_block(action, block_in));
			if (out_valid && !out_stall) begin
				if (block_queue.size() == 0) begin
					$error("unexpected result block_out=%h", block_out);
					fail_count <= fail_count + 1;
				end else begin
					logic [63:0] want;
					want = block_queue.pop_front();
					if (want !== block_out) begin
						$error("block_out mismatch: expected %h, actual %h", want, block_out);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending_count <= block_queue.size();
		end
	end
endmodule

`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the cipher: directed and random blocks over several key and
// round settings, random idling on both channels, and the final verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CycleLimit = 4000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        action = 1'b0;
	logic [63:0] block_in = '0;
	logic        out_stall = 1'b0;
	wire         in_stall, out_valid;
	wire  [63:0] block_out;
	int          fail_count, pending_count;
	longint      cycle_count = 0;
	bit          hold_off_req = 1'b0;

	always #10 clk = ~clk;

	idea_block_cipher u_dut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .action, .block_in,
		.out_valid, .out_stall, .block_out
	);

	ibc_checker u_checker (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .action, .block_in,
		.out_valid, .out_stall, .block_out,
		.fail_count, .pending_count
	);

	// write one register; the block must be idle
	task automatic write_reg(logic [1:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// drain everything in flight, then let the block settle
	task automatic wait_idle();
		while (pending_count != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_key(logic [63:0] hi, logic [63:0] lo, logic [4:0] len,
			logic [4:0] rounds);
		wait_idle();
		write_reg(ibc_pkg::REG_KEY_HIGH, hi);
		write_reg(ibc_pkg::REG_KEY_LOW, lo);
		write_reg(ibc_pkg::REG_KEY_LENGTH, {59'd0, len});
		write_reg(ibc_pkg::REG_ROUND_COUNT, {59'd0, rounds});
	endtask

	// offer one transaction, with an optional idle gap first; hold until taken
	task automatic send_block(logic act, logic [63:0] blk, bit gaps);
		@(negedge clk);
		if (gaps && $urandom_range(0, 2) != 0)
			repeat ($urandom_range(0, 19)) @(negedge clk);
		in_valid <= 1'b1;
		action <= act;
		block_in <= blk;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// draw a random block, biased towards words of 0, 0x0001 and 0xFFFF
	function automatic logic [63:0] pick_block();
		logic [63:0] b;
		b = rand64();
		for (int w = 0; w < 4; w++) begin
			case ($urandom_range(0, 7))
				0: b[16*w +: 16] = 16'h0000;
				1: b[16*w +: 16] = 16'hFFFF;
				2: b[16*w +: 16] = 16'h0001;
				default: ;
			endcase
		end
		return b;
	endfunction

	// receiver: draw a wait per transaction, one long hold-off on request
	initial begin
		int  n;
		bit  held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				n = $urandom_range(0, 19);
				if (n != 0) begin
					out_stall <= 1'b1;
					repeat (n) @(negedge clk);
					out_stall <= 1'b0;
				end
				// wait for the next transaction to be taken
				@(posedge clk);
				while (!(out_valid && !out_stall)) @(posedge clk);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("** idea_block_cipher: FAILED **");
			$finish;
		end
	end

	initial begin
		int phase;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset defaults (all-zero key), extremes of the block
		send_block(1'b0, 64'h0, 1'b0);
		send_block(1'b1, 64'h0, 1'b0);
		send_block(1'b0, '1, 1'b0);
		send_block(1'b1, '1, 1'b0);
		send_block(1'b0, 64'h0001_0002_0003_0004, 1'b0);
		// full key, eight rounds
		set_key(64'h0001_0002_0003_0004, 64'h0005_0006_0007_0008, 5'd16, 5'd8);
		send_block(1'b0, 64'h0000_0001_0002_0003, 1'b0);
		send_block(1'b1, 64'h11FB_ED2B_0198_6DE5, 1'b0);
		send_block(1'b0, '1, 1'b0);
		// key length zero and above sixteen, round count zero
		set_key('1, '1, 5'd0, 5'd0);
		send_block(1'b0, 64'h8000_8000_8000_8000, 1'b0);
		send_block(1'b1, 64'h7FFF_7FFF_7FFF_7FFF, 1'b0);
		set_key('1, '1, 5'd31, 5'd0);
		send_block(1'b0, 64'h0, 1'b0);
		send_block(1'b1, '1, 1'b0);
		// single round, maximum and saturating round counts, partial key
		set_key(64'hDEAD_BEEF_0123_4567, 64'h89AB_CDEF_FEDC_BA98, 5'd1, 5'd1);
		send_block(1'b0, 64'h0123_4567_89AB_CDEF, 1'b0);
		send_block(1'b1, 64'h0123_4567_89AB_CDEF, 1'b0);
		set_key(64'hDEAD_BEEF_0123_4567, 64'h89AB_CDEF_FEDC_BA98, 5'd9, 5'd16);
		send_block(1'b0, '1, 1'b0);
		send_block(1'b1, 64'h0, 1'b0);
		set_key(rand64(), rand64(), 5'd16, 5'd31);
		send_block(1'b0, rand64(), 1'b0);
		send_block(1'b1, rand64(), 1'b0);

		// random phases with fresh settings; pressure in the second phase
		for (phase = 0; phase < 19; phase++) begin
			set_key(rand64(), rand64(), 5'($urandom_range(0, 31)),
				5'($urandom_range(0, 20)));
			if (phase == 1) hold_off_req = 1'b1;
			for (int i = 0; i < 100; i++) begin
				send_block(1'($urandom_range(0, 1)), pick_block(),
					phase != 1 && phase % 4 != 3);
				// pause until every expected result has arrived
				if (phase == 2 && i == 50)
					while (pending_count != 0) @(negedge clk);
			end
		end

		wait_idle();
		repeat (200) @(negedge clk);
		if (fail_count == 0) begin
			$display("** idea_block_cipher: PASSED **");
		end else begin
			$display("** idea_block_cipher: FAILED **");
		end
		$finish;
	end
endmodule

`default_nettype wire
